// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, beat types, operation and status codes shared by the queue's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int COUNT_W   = $clog2(DEPTH + 1);
	localparam int CFG_W     = 5;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_DEL = 1'b1
	} op_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		op_t        op;
		logic [7:0] item_prio;
		logic [7:0] item_char;
	} item_t;

	typedef struct packed {
		logic [7:0]         out_prio;
		logic [7:0]         out_char;
		logic [1:0]         status;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic               is_full;
	} result_t;

	typedef struct packed {
		logic [PRIO_BITS-1:0] prio;
		logic [7:0]           ch;
	} entry_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic   add;
		logic   del;
		entry_t ent;
	} cell_cmd_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic   valid;
		logic   greater;
		entry_t ent;
	} cell_link_t;

	function automatic logic [PRIO_BITS-1:0] to_prio(input logic [7:0] v);
		logic [31:0] t;
		t = {24'd0, v};
		return t[PRIO_BITS-1:0];
	endfunction

	function automatic logic [7:0] from_prio(input logic [PRIO_BITS-1:0] p);
		logic [31:0] t;
		t = 32'(p);
		return t[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// A chain of cells kept in ascending priority order; the head cell holds
// the entry that the next delete returns.
//
//   channel  direction  handshake               beat
//   item     in         item_valid/item_stall   op, item_prio, item_char
//   result   out        result_valid/result_stall  removed entry and status
//   cfg      in         cfg_valid/cfg_ready     capacity_in_use
//
// One item per cycle while item_stall is low; its result appears in the
// result register on the next cycle. Every cell compares the new priority
// with its own entry and with its left neighbor's decision, so an add or
// delete updates the whole chain together. The item channel stalls only
// while a result waits on a stalled result channel. Reset empties the queue
// at once through the cells' valid bits and sets the capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	output logic                             item_stall,
	input  spq_pkg::item_t                   item,
	output logic                             result_valid,
	input  wire                              result_stall,
	output spq_pkg::result_t                 result,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [spq_pkg::CFG_W-1:0]         cfg_data
);

	logic [spq_pkg::COUNT_W-1:0] count_q;
	logic [spq_pkg::COUNT_W-1:0] cap_q;
	logic [spq_pkg::COUNT_W-1:0] cap_in;
	logic [spq_pkg::COUNT_W-1:0] count_next;
	logic                        accept;
	logic                        full_now;
	logic                        empty_now;
	logic                        do_add;
	logic                        do_del;
	spq_pkg::cell_cmd_t          cmd;
	spq_pkg::cell_link_t         links [spq_pkg::DEPTH];
	spq_pkg::result_t            result_q;
	logic                        result_valid_q;
	logic [spq_pkg::DEPTH-1:0]   cell_valid;

	localparam spq_pkg::cell_link_t HEAD_LINK = '{valid: 1'b1, greater: 1'b0, ent: '0};
	localparam spq_pkg::cell_link_t TAIL_LINK = '{valid: 1'b0, greater: 1'b1, ent: '0};

	assign cfg_ready    = 1'b1;
	assign item_stall   = result_valid_q && result_stall;
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		if (cfg_data == '0) begin
			cap_in = spq_pkg::COUNT_W'(1);
		end else if (32'(cfg_data) > spq_pkg::DEPTH) begin
			cap_in = spq_pkg::COUNT_W'(spq_pkg::DEPTH);
		end else begin
			cap_in = spq_pkg::COUNT_W'(cfg_data);
		end
	end

	assign full_now  = count_q >= cap_q;
	assign empty_now = count_q == '0;
	assign do_add    = accept && (item.op == spq_pkg::OP_ADD) && !full_now;
	assign do_del    = accept && (item.op == spq_pkg::OP_DEL) && !empty_now;

	assign cmd.add      = do_add;
	assign cmd.del      = do_del;
	assign cmd.ent.prio = spq_pkg::to_prio(item.item_prio);
	assign cmd.ent.ch   = item.item_char;

	genvar gi;
	generate
		for (gi = 0; gi < spq_pkg::DEPTH; gi++) begin : g_cell
			spq_pkg::cell_link_t left_link;
			spq_pkg::cell_link_t right_link;
			if (gi == 0) begin : g_head
				assign left_link = HEAD_LINK;
			end else begin : g_mid
				assign left_link = links[gi-1];
			end
			if (gi == spq_pkg::DEPTH - 1) begin : g_tail
				assign right_link = TAIL_LINK;
			end else begin : g_body
				assign right_link = links[gi+1];
			end
			spq_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.left   (left_link),
				.right  (right_link),
				.link   (links[gi])
			);
			assign cell_valid[gi] = links[gi].valid;
		end
	endgenerate

	always_comb begin
		if (do_add) begin
			count_next = count_q + spq_pkg::COUNT_W'(1);
		end else if (do_del) begin
			count_next = count_q - spq_pkg::COUNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			cap_q          <= spq_pkg::COUNT_W'(spq_pkg::DEPTH);
			result_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cap_in;
			end
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.out_prio    <= do_del ? spq_pkg::from_prio(links[0].ent.prio) : 8'd0;
			result_q.out_char    <= do_del ? links[0].ent.ch : 8'd0;
			result_q.entry_count <= count_next;
			result_q.is_empty    <= count_next == '0;
			result_q.is_full     <= count_next >= cap_q;
			if (item.op == spq_pkg::OP_ADD) begin
				result_q.status <= full_now ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
			end else begin
				result_q.status <= empty_now ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
			end
		end
	end

	// The occupied cells always form a prefix of the chain, as long as the count.
	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == (count_q != '0))
		else $error("head cell occupancy disagrees with entry count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= spq_pkg::DEPTH)
		else $error("entry count beyond chain depth");

	a_prefix_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(count_q))
		else $error("number of occupied cells differs from entry count");

	a_empty_reject: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == spq_pkg::OP_DEL && empty_now |=>
		result_valid && result.status == spq_pkg::ST_EMPTY && result.is_empty)
		else $error("delete from empty queue not rejected");

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// and left on delete.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  spq_pkg::cell_cmd_t       cmd,
	input  spq_pkg::cell_link_t      left,
	input  spq_pkg::cell_link_t      right,
	output spq_pkg::cell_link_t      link
);

	logic            valid_q;
	spq_pkg::entry_t ent_q;
	logic            greater;

	// The new entry belongs before this slot if the slot is free or holds a
	// strictly larger priority, so equal priorities keep arrival order.
	assign greater = !valid_q || (cmd.ent.prio < ent_q.prio);

	assign link.valid   = valid_q;
	assign link.greater = greater;
	assign link.ent     = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.del) begin
			valid_q <= right.valid;
		end else if (cmd.add) begin
			if (left.greater) begin
				valid_q <= left.valid;
			end else if (greater) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.del) begin
			ent_q <= right.ent;
		end else if (cmd.add) begin
			if (left.greater) begin
				ent_q <= left.ent;
			end else if (greater) begin
				ent_q <= cmd.ent;
			end
		end
	end

endmodule

`default_nettype wire
